FILE: hdl/timeout_message_queue_defines.svh
// Assertion macros for the timeout message queue.
// Included by the RTL file that carries the concurrent checks; no other dependency.
`ifndef TIMEOUT_MESSAGE_QUEUE_DEFINES_SVH
`define TIMEOUT_MESSAGE_QUEUE_DEFINES_SVH

`ifndef SYNTH
// Check a property on the rising clock edge, off while reset is low
`define TMQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("timeout_message_queue: check failed");
// Check a property on the rising clock edge, also during reset
`define TMQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("timeout_message_queue: check failed");
`else
`define TMQ_ASSERT(label, clk, rst_n, prop)
`define TMQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: hdl/tmq_pkg.sv
// Shared types, constants and ring addressing for the timeout message queue.
// No dependencies; used by timeout_message_queue, tmq_alu and the bench.
`default_nettype none

package tmq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;

    localparam int TIME_W   = 32;
    localparam int HANDLE_W = 8;
    localparam int DEST_W   = 4;
    localparam int DELAY_W  = 16;

    // Ring address, entry count and per-tick result count widths
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    // Request and result codes
    localparam logic REQ_INSERT   = 1'b0;
    localparam logic REQ_TICK     = 1'b1;
    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_REJECT  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]   expiry;
        logic [HANDLE_W-1:0] handle;
        logic [DEST_W-1:0]   dest;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Flags and sum from the shared arithmetic unit
    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              lt;
        logic              le;
    } t_alu_res;

    // Physical slot of the entry at offset off from the front slot base
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
        if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
            s = s - (CW + 1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/timeout_message_queue.sv
// Insert: busy while the walk from the tail moves later or equal entries one slot back;
// a full store gives the reject result in the next cycle, never busy.
// Tick: busy while expired entries are popped from the front, until one has not expired,
// the queue empties or the limit hits; the last result comes in the first idle cycle. One RAM
// read port and one shared add/compare unit serve both; a request is taken whenever busy is low.
// Receiver cannot stall results. Reset (synchronous, active low) empties queue, zeroes time.
`default_nettype none
`include "timeout_message_queue_defines.svh"

module timeout_message_queue (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_req_type,
    input  wire logic [tmq_pkg::HANDLE_W-1:0]    i_msg_handle,
    input  wire logic [tmq_pkg::DEST_W-1:0]      i_dest_pid,
    input  wire logic [tmq_pkg::DELAY_W-1:0]     i_delay,
    output logic                                 o_strobe,
    output logic                                 o_kind,
    output logic      [tmq_pkg::HANDLE_W-1:0]    o_out_handle,
    output logic      [tmq_pkg::DEST_W-1:0]      o_out_dest,
    output logic                                 o_last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INS_RD = 3'd1;
    localparam logic [2:0] ST_INS_CK = 3'd2;
    localparam logic [2:0] ST_POP_RD = 3'd3;
    localparam logic [2:0] ST_POP_CK = 3'd4;

    logic [2:0]                     r_state, n_state;
    logic [tmq_pkg::TIME_W-1:0]     r_time, n_time;
    logic [tmq_pkg::AW-1:0]         r_head, n_head;
    logic [tmq_pkg::CW-1:0]         r_count, n_count;
    logic [tmq_pkg::CW-1:0]         r_idx, n_idx;
    logic [tmq_pkg::NW-1:0]         r_nres, n_nres;
    tmq_pkg::t_entry                r_new, n_new;
    logic                           r_pend_valid, n_pend_valid;
    logic [tmq_pkg::HANDLE_W-1:0]   r_pend_handle, n_pend_handle;
    logic [tmq_pkg::DEST_W-1:0]     r_pend_dest, n_pend_dest;
    logic                           r_strobe, n_strobe;
    logic                           r_kind, n_kind;
    logic [tmq_pkg::HANDLE_W-1:0]   r_handle, n_handle;
    logic [tmq_pkg::DEST_W-1:0]     r_dest, n_dest;
    logic                           r_last, n_last;

    logic                           accept;
    logic                           ram_we, ram_re;
    logic [tmq_pkg::AW-1:0]         ram_waddr, ram_raddr;
    tmq_pkg::t_entry                ram_wdata, ram_rdata;
    logic [tmq_pkg::TIME_W-1:0]     alu_a, alu_b;
    tmq_pkg::t_alu_res              alu_res;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Entry store, kept as a ring with the front at r_head
    tmq_ram #(
        .WIDTH (tmq_pkg::ENTRY_W),
        .DEPTH (tmq_pkg::QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared unit: time update or new expiry sum when idle, expiry compare when checking an entry
    always_comb begin
        if (r_state == ST_IDLE) begin
            alu_a = r_time;
            alu_b = (i_req_type == tmq_pkg::REQ_TICK) ? tmq_pkg::TIME_W'(1)
                  : {{(tmq_pkg::TIME_W - tmq_pkg::DELAY_W){1'b0}}, i_delay};
        end else begin
            alu_a = ram_rdata.expiry;
            alu_b = (r_state == ST_INS_CK) ? r_new.expiry : r_time;
        end
    end

    tmq_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Sequencer: insertion walks from the tail, ticks pop from the front
    always_comb begin
        n_state       = r_state;
        n_time        = r_time;
        n_head        = r_head;
        n_count       = r_count;
        n_idx         = r_idx;
        n_nres        = r_nres;
        n_new         = r_new;
        n_pend_valid  = r_pend_valid;
        n_pend_handle = r_pend_handle;
        n_pend_dest   = r_pend_dest;
        n_strobe      = 1'b0;
        n_kind        = r_kind;
        n_handle      = r_handle;
        n_dest        = r_dest;
        n_last        = r_last;
        ram_we        = 1'b0;
        ram_waddr     = r_head;
        ram_wdata     = r_new;
        ram_re        = 1'b0;
        ram_raddr     = r_head;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req_type == tmq_pkg::REQ_TICK) begin
                        n_time       = alu_res.sum;
                        n_nres       = '0;
                        n_pend_valid = 1'b0;
                        n_state      = ST_POP_RD;
                    end else if (r_count == tmq_pkg::CW'(tmq_pkg::QUEUE_DEPTH)) begin
                        // Store full: reject the request at once
                        n_strobe = 1'b1;
                        n_kind   = tmq_pkg::KIND_REJECT;
                        n_handle = i_msg_handle;
                        n_dest   = i_dest_pid;
                        n_last   = 1'b1;
                    end else begin
                        n_new.expiry = alu_res.sum;
                        n_new.handle = i_msg_handle;
                        n_new.dest   = i_dest_pid;
                        n_idx        = r_count;
                        n_state      = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                if (r_idx == '0) begin
                    // Reached the front: place the new entry there
                    ram_we    = 1'b1;
                    ram_waddr = r_head;
                    ram_wdata = r_new;
                    n_count   = r_count + 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = tmq_pkg::ring_addr(r_head, r_idx - 1'b1);
                    n_state   = ST_INS_CK;
                end
            end
            ST_INS_CK: begin
                ram_we    = 1'b1;
                ram_waddr = tmq_pkg::ring_addr(r_head, r_idx);
                if (alu_res.lt) begin
                    // Earlier entry found: new entry goes right behind it
                    ram_wdata = r_new;
                    n_count   = r_count + 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    // Move the later or equal entry one slot back
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - 1'b1;
                    n_state   = ST_INS_RD;
                end
            end
            ST_POP_RD: begin
                if (r_count == '0 || r_nres == tmq_pkg::NW'(tmq_pkg::MAX_RESULTS)) begin
                    if (r_pend_valid) begin
                        n_strobe = 1'b1;
                        n_kind   = tmq_pkg::KIND_DELIVER;
                        n_handle = r_pend_handle;
                        n_dest   = r_pend_dest;
                        n_last   = 1'b1;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_head;
                    n_state   = ST_POP_CK;
                end
            end
            ST_POP_CK: begin
                if (r_pend_valid) begin
                    n_strobe = 1'b1;
                    n_kind   = tmq_pkg::KIND_DELIVER;
                    n_handle = r_pend_handle;
                    n_dest   = r_pend_dest;
                    n_last   = !alu_res.le;
                end
                if (alu_res.le) begin
                    // Expired: hold it until we know whether it is the last
                    n_pend_valid  = 1'b1;
                    n_pend_handle = ram_rdata.handle;
                    n_pend_dest   = ram_rdata.dest;
                    n_head        = tmq_pkg::ring_addr(r_head, tmq_pkg::CW'(1));
                    n_count       = r_count - 1'b1;
                    n_nres        = r_nres + 1'b1;
                    n_state       = ST_POP_RD;
                end else begin
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_time       <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_nres       <= '0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_time       <= n_time;
            r_head       <= n_head;
            r_count      <= n_count;
            r_nres       <= n_nres;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_new         <= n_new;
        r_pend_handle <= n_pend_handle;
        r_pend_dest   <= n_pend_dest;
        r_kind        <= n_kind;
        r_handle      <= n_handle;
        r_dest        <= n_dest;
        r_last        <= n_last;
    end

    assign o_strobe     = r_strobe;
    assign o_kind       = r_kind;
    assign o_out_handle = r_handle;
    assign o_out_dest   = r_dest;
    assign o_last       = r_last;

    // Checks
    `TMQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= tmq_pkg::CW'(tmq_pkg::QUEUE_DEPTH))
    `TMQ_ASSERT(a_nres_bound, i_clk, i_rst_n, r_nres <= tmq_pkg::NW'(tmq_pkg::MAX_RESULTS))
    `TMQ_ASSERT(a_reject_cause, i_clk, i_rst_n, (o_strobe && o_kind == tmq_pkg::KIND_REJECT) |-> $past(accept && i_req_type == tmq_pkg::REQ_INSERT))
    `TMQ_ASSERT(a_deliver_in_tick, i_clk, i_rst_n, (o_strobe && o_kind == tmq_pkg::KIND_DELIVER) |-> $past(r_state == ST_POP_RD || r_state == ST_POP_CK))
    `TMQ_ASSERT(a_tick_busy, i_clk, i_rst_n, (accept && i_req_type == tmq_pkg::REQ_TICK) |=> busy)
    `TMQ_ASSERT_ALWAYS(a_reset_quiet, i_clk, !$past(i_rst_n) |-> !o_strobe)

endmodule

`default_nettype wire

FILE: hdl/tmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/tmq_alu.sv
// Shared 32-bit adder and unsigned comparator of the timeout message queue.
// Depends on tmq_pkg.
`default_nettype none

module tmq_alu (
    input  wire logic [tmq_pkg::TIME_W-1:0] i_a,
    input  wire logic [tmq_pkg::TIME_W-1:0] i_b,
    output tmq_pkg::t_alu_res               o_res
);

    // Wrapping sum and unsigned ordering of the two operands
    always_comb begin
        o_res.sum = i_a + i_b;
        o_res.lt  = (i_a < i_b);
        o_res.le  = (i_a <= i_b);
    end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking bench for the timeout message queue: queued requests, a clocked driver,
// a strobe monitor and a sorted-queue predictor of deliveries and rejects.
// Depends on tmq_pkg and the timeout_message_queue top level only.
`timescale 1ns / 1ps

module tb_top;
    import tmq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_ITEMS   = 460;
    localparam int DRAIN_WAIT  = 200;

    typedef struct {
        logic                req;
        logic [HANDLE_W-1:0] handle;
        logic [DEST_W-1:0]   dest;
        logic [DELAY_W-1:0]  delay;
        bit                  hold;
    } req_t;

    typedef struct {
        logic                kind;
        logic [HANDLE_W-1:0] handle;
        logic [DEST_W-1:0]   dest;
        logic                last;
    } msg_t;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic                busy;
    logic                i_req_type   = REQ_TICK;
    logic [HANDLE_W-1:0] i_msg_handle = '0;
    logic [DEST_W-1:0]   i_dest_pid   = '0;
    logic [DELAY_W-1:0]  i_delay      = '0;
    logic                o_strobe;
    logic                o_kind;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [DEST_W-1:0]   o_out_dest;
    logic                o_last;

    timeout_message_queue u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_msg_handle (i_msg_handle),
        .i_dest_pid   (i_dest_pid),
        .i_delay      (i_delay),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_out_handle (o_out_handle),
        .o_out_dest   (o_out_dest),
        .o_last       (o_last)
    );

    // Predicted timer store, front at index 0
    logic [TIME_W-1:0]   tq_expiry [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] tq_handle [QUEUE_DEPTH];
    logic [DEST_W-1:0]   tq_dest   [QUEUE_DEPTH];
    int                  tq_count = 0;
    logic [TIME_W-1:0]   ms_now   = '0;

    req_t pending_reqs [$];
    msg_t due_msgs     [$];
    req_t cur_req;

    int n_errors   = 0;
    int n_accepted = 0;
    int n_inserts  = 0;
    int n_ticks    = 0;
    int n_delivers = 0;
    int n_rejects  = 0;
    int n_items    = 0;
    int wide_left  = 5;
    int cycles     = 0;

    // Clock: 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 0;
    end

    // Hold reset low at the start, then release it once
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    // Advance the predicted store by one accepted request, queue what it emits
    task automatic track_request(input req_t r);
        logic [TIME_W-1:0] due_at;
        int                pos;
        int                n;
        msg_t              m;
        if (r.req == REQ_INSERT) begin
            n_inserts++;
            if (tq_count >= QUEUE_DEPTH) begin
                m = '{KIND_REJECT, r.handle, r.dest, 1'b1};
                due_msgs.push_back(m);
            end else begin
                due_at = ms_now + TIME_W'(r.delay);
                pos = 0;
                // land ahead of entries with equal or later expiry
                while (pos < tq_count && tq_expiry[pos] < due_at) pos++;
                for (int i = tq_count; i > pos; i--) begin
                    tq_expiry[i] = tq_expiry[i-1];
                    tq_handle[i] = tq_handle[i-1];
                    tq_dest[i]   = tq_dest[i-1];
                end
                tq_expiry[pos] = due_at;
                tq_handle[pos] = r.handle;
                tq_dest[pos]   = r.dest;
                tq_count++;
            end
        end else begin
            n_ticks++;
            ms_now = ms_now + 1'b1;
            n = 0;
            // pop expired front entries, up to MAX_RESULTS
            while (n < MAX_RESULTS && tq_count > 0 && tq_expiry[0] <= ms_now) begin
                m = '{KIND_DELIVER, tq_handle[0], tq_dest[0], 1'b0};
                due_msgs.push_back(m);
                n++;
                for (int i = 1; i < tq_count; i++) begin
                    tq_expiry[i-1] = tq_expiry[i];
                    tq_handle[i-1] = tq_handle[i];
                    tq_dest[i-1]   = tq_dest[i];
                end
                tq_count--;
            end
            if (n > 0) begin
                m = due_msgs[due_msgs.size()-1];
                m.last = 1'b1;
                due_msgs[due_msgs.size()-1] = m;
            end
        end
    endtask

    // Driver: hold the request until accepted, then load the next or idle
    always @(posedge i_clk) begin : drive_proc
        req_t nxt;
        bit   quiet;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                track_request(cur_req);
                n_accepted++;
            end
            if (!start || !busy) begin
                // drop a pause marker once nothing is outstanding
                if (pending_reqs.size() > 0 && pending_reqs[0].hold && due_msgs.size() == 0) begin
                    void'(pending_reqs.pop_front());
                end
                quiet = (n_accepted >= 200 && n_accepted < 300);
                if (pending_reqs.size() > 0 && !pending_reqs[0].hold &&
                    (quiet || $urandom_range(0, 99) >= 13)) begin
                    nxt = pending_reqs.pop_front();
                    cur_req      = nxt;
                    start        <= 1'b1;
                    i_req_type   <= nxt.req;
                    i_msg_handle <= nxt.handle;
                    i_dest_pid   <= nxt.dest;
                    i_delay      <= nxt.delay;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: sample mid-cycle, compare with the oldest expected result
    always @(negedge i_clk) begin : watch_proc
        msg_t m;
        if (i_rst_n && o_strobe) begin
            if (o_kind === KIND_REJECT) n_rejects++;
            else n_delivers++;
            if (due_msgs.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0b handle 0x%0h",
                                          o_kind, o_out_handle));
            end else begin
                m = due_msgs.pop_front();
                check_field("kind", 32'(o_kind), 32'(m.kind));
                check_field("handle", 32'(o_out_handle), 32'(m.handle));
                check_field("dest", 32'(o_out_dest), 32'(m.dest));
                check_field("last", 32'(o_last), 32'(m.last));
            end
        end
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("timeout_message_queue regression: fail");
            $finish;
        end
    end

    task automatic push_raw(input logic req, input logic [HANDLE_W-1:0] h,
                            input logic [DEST_W-1:0] d, input logic [DELAY_W-1:0] dl);
        req_t r;
        r = '{req, h, d, dl, 1'b0};
        pending_reqs.push_back(r);
        n_items++;
    endtask

    task automatic push_insert(input logic [DELAY_W-1:0] dl);
        push_raw(REQ_INSERT, HANDLE_W'($urandom), DEST_W'($urandom), dl);
    endtask

    // Ticks carry junk in the unused fields
    task automatic push_ticks(input int cnt);
        for (int i = 0; i < cnt; i++) begin
            push_raw(REQ_TICK, HANDLE_W'($urandom), DEST_W'($urandom), DELAY_W'($urandom));
        end
    endtask

    task automatic push_hold();
        req_t r;
        r = '{REQ_TICK, '0, '0, '0, 1'b1};
        pending_reqs.push_back(r);
    endtask

    // Fill past capacity, then release the burst
    task automatic push_fill();
        for (int i = 0; i < QUEUE_DEPTH + 2; i++) push_insert(DELAY_W'($urandom_range(1, 3)));
        push_ticks(4);
    endtask

    initial begin : stim_proc
        int r;
        int cnt;
        // Directed: empty tick, extremes, equal expiry, several per tick
        push_raw(REQ_TICK, 8'hFF, 4'hF, 16'hFFFF);
        push_raw(REQ_INSERT, 8'h00, 4'h0, 16'h0000);
        push_ticks(1);
        push_raw(REQ_INSERT, 8'hFF, 4'hF, 16'hFFFF);
        push_raw(REQ_INSERT, 8'h10, 4'h1, 16'd3);
        push_raw(REQ_INSERT, 8'h11, 4'h2, 16'd3);
        push_raw(REQ_INSERT, 8'h12, 4'h3, 16'd3);
        push_raw(REQ_INSERT, 8'h13, 4'h4, 16'd1);
        push_raw(REQ_INSERT, 8'h14, 4'h5, 16'd5);
        push_raw(REQ_INSERT, 8'h15, 4'h6, 16'd2);
        push_ticks(6);
        push_hold();
        push_raw(REQ_INSERT, 8'h20, 4'h7, 16'd0);
        push_raw(REQ_INSERT, 8'h21, 4'h8, 16'd0);
        push_ticks(2);
        push_hold();
        push_fill();

        // Random: mostly insert bursts followed by ticks
        while (n_items < NUM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                cnt = $urandom_range(1, 6);
                for (int i = 0; i < cnt; i++) push_insert(DELAY_W'($urandom_range(0, 8)));
                push_ticks($urandom_range(1, 10));
            end else if (r < 65) begin
                if ($urandom_range(0, 1) == 1) push_ticks(1);
                else push_insert(DELAY_W'($urandom_range(0, 20)));
            end else if (r < 72) begin
                push_fill();
            end else if (r < 77) begin
                if (wide_left > 0) begin
                    push_insert(DELAY_W'($urandom));
                    wide_left--;
                end
            end else if (r < 90) begin
                push_ticks($urandom_range(5, 20));
            end else begin
                push_hold();
                push_insert(DELAY_W'($urandom_range(0, 4)));
                push_ticks($urandom_range(1, 4));
            end
        end

        // Wait for acceptance, then for results, then let the pipe settle
        while (pending_reqs.size() > 0 || start) @(posedge i_clk);
        while (due_msgs.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (due_msgs.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived", due_msgs.size()));
        end
        $display("run: %0d requests (%0d inserts, %0d ticks), time reached %0d ms",
                 n_accepted, n_inserts, n_ticks, ms_now);
        $display("results seen: %0d deliveries, %0d rejects, %0d mismatches",
                 n_delivers, n_rejects, n_errors);
        if (n_errors == 0) begin
            $display("timeout_message_queue regression: pass");
        end else begin
            $display("timeout_message_queue regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/tmq_pkg.sv
hdl/tmq_ram.sv
hdl/tmq_alu.sv
hdl/timeout_message_queue.sv
dv/tb_top.sv
